FILE: src/dxtd_pkg.sv
// Shared types, constants and decode functions for the DXT block decoder.
// Used by the channel interfaces, the scaler and the top level; depends on nothing.
package dxtd_pkg;

  // Block and pixel geometry
  localparam int unsigned NumPixels = 16;
  localparam int unsigned PixW      = 4;
  localparam int unsigned ChanW     = 8;

  // Numerator, reciprocal and product widths of the scaling datapath
  localparam int unsigned NumW  = 11;
  localparam int unsigned MultW = 12;
  localparam int unsigned ProdW = NumW + MultW;
  localparam int unsigned ShW   = 4;

  // Block format register codes; the unused code decodes as DXT5
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  // Color palette entries
  localparam logic [1:0] CI_C0   = 2'd0;
  localparam logic [1:0] CI_C1   = 2'd1;
  localparam logic [1:0] CI_MID0 = 2'd2;
  localparam logic [1:0] CI_MID1 = 2'd3;

  // Special alpha ramp entries
  localparam logic [2:0] AI_A0   = 3'd0;
  localparam logic [2:0] AI_A1   = 3'd1;
  localparam logic [2:0] AI_ZERO = 3'd6;
  localparam logic [2:0] AI_FULL = 3'd7;

  // How a numerator is reduced to a component value
  typedef enum logic [2:0] {
    OP_PASS,
    OP_HALF,
    OP_THIRD,
    OP_FIFTH,
    OP_SEVENTH
  } op_e;

  // One component on its way to the scaler: numerator and reduction
  typedef struct packed {
    logic [NumW-1:0] num;
    op_e             op;
  } chan_t;

  // Reciprocal multiplier; products stay exact for every numerator in range.
  function automatic logic [MultW-1:0] op_mult(input op_e op);
    logic [MultW-1:0] m;
    unique case (op)
      OP_THIRD:   m = 12'd683;
      OP_FIFTH:   m = 12'd1639;
      OP_SEVENTH: m = 12'd2341;
      default:    m = 12'd1;
    endcase
    return m;
  endfunction

  // Right shift that pairs with the reciprocal above.
  function automatic logic [ShW-1:0] op_shift(input op_e op);
    logic [ShW-1:0] s;
    unique case (op)
      OP_HALF:    s = 4'd1;
      OP_THIRD:   s = 4'd11;
      OP_FIFTH:   s = 4'd13;
      OP_SEVENTH: s = 4'd14;
      default:    s = 4'd0;
    endcase
    return s;
  endfunction

  // Color palette entry for one channel of widened endpoints.
  function automatic chan_t color_chan(input logic [1:0] ci, input logic three,
                                       input logic [ChanW-1:0] e0,
                                       input logic [ChanW-1:0] e1);
    logic [NumW-1:0] x0;
    logic [NumW-1:0] x1;
    chan_t           c;
    x0 = {3'd0, e0};
    x1 = {3'd0, e1};
    unique case (ci)
      CI_C0: begin
        c.num = x0;
        c.op  = OP_PASS;
      end
      CI_C1: begin
        c.num = x1;
        c.op  = OP_PASS;
      end
      CI_MID0: begin
        c.num = three ? (x0 + x1) : ((x0 << 1) + x1);
        c.op  = three ? OP_HALF : OP_THIRD;
      end
      default: begin
        c.num = three ? '0 : (x0 + (x1 << 1));
        c.op  = three ? OP_PASS : OP_THIRD;
      end
    endcase
    return c;
  endfunction

  // Interpolated alpha ramp entry.
  function automatic chan_t alpha_ramp(input logic [2:0] ai, input logic [ChanW-1:0] a0,
                                       input logic [ChanW-1:0] a1);
    logic [NumW-1:0] x0;
    logic [NumW-1:0] x1;
    logic [NumW-1:0] aix;
    logic [NumW-1:0] w0;
    logic [NumW-1:0] w1;
    chan_t           c;
    x0  = {3'd0, a0};
    x1  = {3'd0, a1};
    aix = {8'd0, ai};
    w0  = '0;
    w1  = '0;
    if (ai == AI_A0) begin
      c.num = x0;
      c.op  = OP_PASS;
    end else if (ai == AI_A1) begin
      c.num = x1;
      c.op  = OP_PASS;
    end else if (a0 > a1) begin
      w0    = 11'd8 - aix;
      w1    = aix - 11'd1;
      c.num = w0 * x0 + w1 * x1;
      c.op  = OP_SEVENTH;
    end else if (ai == AI_ZERO) begin
      c.num = '0;
      c.op  = OP_PASS;
    end else if (ai == AI_FULL) begin
      c.num = 11'd255;
      c.op  = OP_PASS;
    end else begin
      w0    = 11'd6 - aix;
      w1    = aix - 11'd1;
      c.num = w0 * x0 + w1 * x1;
      c.op  = OP_FIFTH;
    end
    return c;
  endfunction

endpackage

FILE: src/dxtd_intf.sv
// Valid/ready channel interfaces: compressed block in, pixel out, format write.
// Depends on dxtd_pkg for the pixel field widths.
interface dxtd_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] alpha_word;
  logic [15:0] color0;
  logic [15:0] color1;
  logic [31:0] index_word;

  modport source (output valid, alpha_word, color0, color1, index_word, input ready);
  modport sink   (input valid, alpha_word, color0, color1, index_word, output ready);
endinterface

interface dxtd_pix_if;
  logic                          valid;
  logic                          ready;
  logic [dxtd_pkg::PixW-1:0]     pixel_index;
  logic [dxtd_pkg::ChanW-1:0]    red;
  logic [dxtd_pkg::ChanW-1:0]    green;
  logic [dxtd_pkg::ChanW-1:0]    blue;
  logic [dxtd_pkg::ChanW-1:0]    alpha;
  logic                          last_pixel;

  modport source (output valid, pixel_index, red, green, blue, alpha, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_index, red, green, blue, alpha, last_pixel,
                  output ready);
endinterface

interface dxtd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] block_format;

  modport source (output valid, block_format, input ready);
  modport sink   (input valid, block_format, output ready);
endinterface

FILE: src/dxtd_scaler.sv
// Two-stage component scaler: reciprocal multiply, then shift into 8 bits.
// Depends on dxtd_pkg for chan_t and the reciprocal tables.
module dxtd_scaler (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  dxtd_pkg::chan_t            chan_i,
  output logic [dxtd_pkg::ChanW-1:0] res_o
);

  logic [dxtd_pkg::ProdW-1:0] prod_q;
  dxtd_pkg::op_e              op_q;
  logic [dxtd_pkg::ChanW-1:0] res_q;

  // Multiply stage: numerator times reciprocal of the divisor.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= {12'd0, chan_i.num} * {11'd0, dxtd_pkg::op_mult(chan_i.op)};
      op_q   <= chan_i.op;
    end
  end

  // Shift stage, which is also the output register of the component.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= dxtd_pkg::ChanW'(prod_q >> dxtd_pkg::op_shift(op_q));
    end
  end

  assign res_o = res_q;

endmodule

FILE: src/dxt_block_decoder.sv
// DXT1/DXT3/DXT5 4x4 block decoder, sixteen RGBA pixel beats per block beat.
// One pixel per cycle while pix_o is not stalled; the next block is accepted on the
// cycle its predecessor issues pixel 15 into the four-stage pixel pipe.
// Reset clears the format register to DXT1 and empties every stage.
// Depends on dxtd_pkg, the channel interfaces and dxtd_scaler.
module dxt_block_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  dxtd_cfg_if.sink   cfg_i,
  dxtd_blk_if.sink   blk_i,
  dxtd_pix_if.source pix_o
);

  localparam int unsigned PixW  = dxtd_pkg::PixW;
  localparam int unsigned ChanW = dxtd_pkg::ChanW;

  // Format register
  logic [1:0] fmt_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= dxtd_pkg::FMT_DXT1;
    end else if (cfg_i.valid) begin
      fmt_q <= cfg_i.block_format;
    end
  end

  // Pipeline advance: the output register is empty or being drained.
  logic adv;
  logic v4_q;

  assign adv = !v4_q || pix_o.ready;

  // Block holding register and pixel counter
  logic            blk_vld_q;
  logic [63:0]     aw_q;
  logic [15:0]     c0_q;
  logic [15:0]     c1_q;
  logic [31:0]     idx_q;
  logic [1:0]      bfmt_q;
  logic            three_q;
  logic [PixW-1:0] cnt_q;
  logic            issue;
  logic            last_issue;
  logic            blk_fire;

  assign issue      = blk_vld_q && adv;
  assign last_issue = issue && (cnt_q == PixW'(dxtd_pkg::NumPixels - 1));
  assign blk_i.ready = !blk_vld_q || last_issue;
  assign blk_fire   = blk_i.valid && blk_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else if (blk_fire) begin
      blk_vld_q <= 1'b1;
      cnt_q     <= '0;
    end else if (issue) begin
      blk_vld_q <= !last_issue;
      cnt_q     <= cnt_q + PixW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_fire) begin
      aw_q    <= blk_i.alpha_word;
      c0_q    <= blk_i.color0;
      c1_q    <= blk_i.color1;
      idx_q   <= blk_i.index_word;
      bfmt_q  <= fmt_q;
      three_q <= (fmt_q == dxtd_pkg::FMT_DXT1) && (blk_i.color0 <= blk_i.color1);
    end
  end

  // Per-pixel fields of the held block
  logic [15:0][1:0] ci_arr;
  logic [15:0][3:0] nib_arr;
  logic [15:0][2:0] ai_arr;

  assign ci_arr  = idx_q;
  assign nib_arr = aw_q;
  assign ai_arr  = aw_q[63:16];

  // Stage 1: select this pixel's indices and carry the block endpoints.
  logic            v1_q;
  logic [PixW-1:0] pix1_q;
  logic            last1_q;
  logic [1:0]      ci1_q;
  logic [3:0]      nib1_q;
  logic [2:0]      ai1_q;
  logic [1:0]      fmt1_q;
  logic            three1_q;
  logic [15:0]     c01_q;
  logic [15:0]     c11_q;
  logic [7:0]      a01_q;
  logic [7:0]      a11_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix1_q   <= cnt_q;
      last1_q  <= (cnt_q == PixW'(dxtd_pkg::NumPixels - 1));
      ci1_q    <= ci_arr[cnt_q];
      nib1_q   <= nib_arr[cnt_q];
      ai1_q    <= ai_arr[cnt_q];
      fmt1_q   <= bfmt_q;
      three1_q <= three_q;
      c01_q    <= c0_q;
      c11_q    <= c1_q;
      a01_q    <= aw_q[7:0];
      a11_q    <= aw_q[15:8];
    end
  end

  // Stage 2: weighted numerators and the reduction each needs.
  logic [ChanW-1:0] r0;
  logic [ChanW-1:0] g0;
  logic [ChanW-1:0] b0;
  logic [ChanW-1:0] r1;
  logic [ChanW-1:0] g1;
  logic [ChanW-1:0] b1;
  dxtd_pkg::chan_t  alpha_d;

  assign r0 = {c01_q[15:11], 3'b000};
  assign g0 = {c01_q[10:5], 2'b00};
  assign b0 = {c01_q[4:0], 3'b000};
  assign r1 = {c11_q[15:11], 3'b000};
  assign g1 = {c11_q[10:5], 2'b00};
  assign b1 = {c11_q[4:0], 3'b000};

  always_comb begin
    unique case (fmt1_q)
      dxtd_pkg::FMT_DXT1: begin
        alpha_d.num = (three1_q && (ci1_q == dxtd_pkg::CI_MID1)) ? 11'd0 : 11'd255;
        alpha_d.op  = dxtd_pkg::OP_PASS;
      end
      dxtd_pkg::FMT_DXT3: begin
        alpha_d.num = {3'd0, nib1_q, nib1_q};
        alpha_d.op  = dxtd_pkg::OP_PASS;
      end
      default: begin
        alpha_d = dxtd_pkg::alpha_ramp(ai1_q, a01_q, a11_q);
      end
    endcase
  end

  logic            v2_q;
  logic [PixW-1:0] pix2_q;
  logic            last2_q;
  dxtd_pkg::chan_t red2_q;
  dxtd_pkg::chan_t green2_q;
  dxtd_pkg::chan_t blue2_q;
  dxtd_pkg::chan_t alpha2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix2_q   <= pix1_q;
      last2_q  <= last1_q;
      red2_q   <= dxtd_pkg::color_chan(ci1_q, three1_q, r0, r1);
      green2_q <= dxtd_pkg::color_chan(ci1_q, three1_q, g0, g1);
      blue2_q  <= dxtd_pkg::color_chan(ci1_q, three1_q, b0, b1);
      alpha2_q <= alpha_d;
    end
  end

  // Stages 3 and 4: reciprocal multiply and shift, one scaler per component.
  logic [ChanW-1:0] red4;
  logic [ChanW-1:0] green4;
  logic [ChanW-1:0] blue4;
  logic [ChanW-1:0] alpha4;

  dxtd_scaler u_red   (.clk_i(clk_i), .en_i(adv), .chan_i(red2_q),   .res_o(red4));
  dxtd_scaler u_green (.clk_i(clk_i), .en_i(adv), .chan_i(green2_q), .res_o(green4));
  dxtd_scaler u_blue  (.clk_i(clk_i), .en_i(adv), .chan_i(blue2_q),  .res_o(blue4));
  dxtd_scaler u_alpha (.clk_i(clk_i), .en_i(adv), .chan_i(alpha2_q), .res_o(alpha4));

  // Valid bits and pixel position alongside the scalers
  logic            v3_q;
  logic [PixW-1:0] pix3_q;
  logic            last3_q;
  logic [PixW-1:0] pix4_q;
  logic            last4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix3_q  <= pix2_q;
      last3_q <= last2_q;
      pix4_q  <= pix3_q;
      last4_q <= last3_q;
    end
  end

  // Output beat
  assign pix_o.valid       = v4_q;
  assign pix_o.pixel_index = pix4_q;
  assign pix_o.red         = red4;
  assign pix_o.green       = green4;
  assign pix_o.blue        = blue4;
  assign pix_o.alpha       = alpha4;
  assign pix_o.last_pixel  = last4_q;

  // A new block always starts issuing from pixel zero.
  a_blk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_fire |=> blk_vld_q && (cnt_q == '0))
    else $error("block accepted but pixel counter not restarted");

  // An issued pixel lands in stage 1 with the position it was issued at.
  a_issue_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> v1_q && (pix1_q == $past(cnt_q)))
    else $error("issued pixel position lost in stage 1");

  // The end-of-block mark travels with pixel fifteen and no other.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (last4_q == (pix4_q == PixW'(dxtd_pkg::NumPixels - 1))))
    else $error("last_pixel does not match pixel_index");

endmodule

FILE: tb/dxt_block_decoder_tb.sv
// Self-checking testbench for the DXT1/DXT3/DXT5 block decoder: drives block and
// format beats, predicts all sixteen pixels per block and checks every pixel beat.
// Depends on dxtd_pkg, the channel interfaces in dxtd_intf.sv and dxt_block_decoder.
module dxt_block_decoder_tb;

  // The unused format code, which the block decodes as DXT5.
  localparam logic [1:0] FMT_SPARE = 2'd3;
  localparam int unsigned IdlePct     = 26;
  localparam int unsigned SettleCyc   = 24;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldOffCyc  = 200;
  localparam int unsigned PhaseBlocks = 40;

  typedef struct packed {
    logic [63:0] alpha_word;
    logic [15:0] color0;
    logic [15:0] color1;
    logic [31:0] index_word;
  } block_t;

  typedef struct packed {
    logic [dxtd_pkg::PixW-1:0]  pixel_index;
    logic [dxtd_pkg::ChanW-1:0] red;
    logic [dxtd_pkg::ChanW-1:0] green;
    logic [dxtd_pkg::ChanW-1:0] blue;
    logic [dxtd_pkg::ChanW-1:0] alpha;
    logic                       last_pixel;
  } pixel_t;

  // Holds the pixels still owed by the decoder and compares each pixel beat.
  class pixel_scoreboard;
    pixel_t      pending_pixels[$];
    int unsigned fail_count;
    int unsigned pixels_checked;

    function new();
      fail_count     = 0;
      pixels_checked = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      fail_count++;
    endtask

    // Decodes one accepted block under the given format into sixteen pixels.
    function void note_block(input logic [1:0] fmt, input block_t blk);
      int unsigned r[4], g[4], b[4], a[4], ramp[8];
      int unsigned a0, a1, ci, k, i, pix_alpha;
      bit          three;
      pixel_t      px;
      r[0] = {blk.color0[15:11], 3'b000};
      g[0] = {blk.color0[10:5], 2'b00};
      b[0] = {blk.color0[4:0], 3'b000};
      r[1] = {blk.color1[15:11], 3'b000};
      g[1] = {blk.color1[10:5], 2'b00};
      b[1] = {blk.color1[4:0], 3'b000};
      for (k = 0; k < 4; k++) a[k] = 255;
      three = (fmt == dxtd_pkg::FMT_DXT1) && (blk.color0 <= blk.color1);
      if (three) begin
        r[2] = (r[0] + r[1]) / 2;
        g[2] = (g[0] + g[1]) / 2;
        b[2] = (b[0] + b[1]) / 2;
        r[3] = 0;
        g[3] = 0;
        b[3] = 0;
        a[3] = 0;
      end else begin
        r[2] = (2 * r[0] + r[1]) / 3;
        g[2] = (2 * g[0] + g[1]) / 3;
        b[2] = (2 * b[0] + b[1]) / 3;
        r[3] = (r[0] + 2 * r[1]) / 3;
        g[3] = (g[0] + 2 * g[1]) / 3;
        b[3] = (b[0] + 2 * b[1]) / 3;
      end
      // Interpolated alpha ramp: eight-entry when a0 > a1, else six plus 0 and 255.
      a0 = blk.alpha_word[7:0];
      a1 = blk.alpha_word[15:8];
      ramp[0] = a0;
      ramp[1] = a1;
      if (a0 > a1) begin
        for (k = 2; k < 8; k++) ramp[k] = ((8 - k) * a0 + (k - 1) * a1) / 7;
      end else begin
        for (k = 2; k < 6; k++) ramp[k] = ((6 - k) * a0 + (k - 1) * a1) / 5;
        ramp[6] = 0;
        ramp[7] = 255;
      end
      for (i = 0; i < dxtd_pkg::NumPixels; i++) begin
        ci = blk.index_word[2*i +: 2];
        if (fmt == dxtd_pkg::FMT_DXT1) pix_alpha = a[ci];
        else if (fmt == dxtd_pkg::FMT_DXT3) pix_alpha = blk.alpha_word[4*i +: 4] * 17;
        else pix_alpha = ramp[blk.alpha_word[16+3*i +: 3]];
        px.pixel_index = i[dxtd_pkg::PixW-1:0];
        px.red         = r[ci][7:0];
        px.green       = g[ci][7:0];
        px.blue        = b[ci][7:0];
        px.alpha       = pix_alpha[7:0];
        px.last_pixel  = (i == dxtd_pkg::NumPixels - 1);
        pending_pixels.push_back(px);
      end
    endfunction

    task check_pixel(input pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel beat %0d", got.pixel_index));
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (got.pixel_index !== want.pixel_index)
          report_mismatch($sformatf("pixel_index got %0d want %0d",
                                    got.pixel_index, want.pixel_index));
        if (got.red !== want.red)
          report_mismatch($sformatf("pixel %0d red got %0d want %0d",
                                    want.pixel_index, got.red, want.red));
        if (got.green !== want.green)
          report_mismatch($sformatf("pixel %0d green got %0d want %0d",
                                    want.pixel_index, got.green, want.green));
        if (got.blue !== want.blue)
          report_mismatch($sformatf("pixel %0d blue got %0d want %0d",
                                    want.pixel_index, got.blue, want.blue));
        if (got.alpha !== want.alpha)
          report_mismatch($sformatf("pixel %0d alpha got %0d want %0d",
                                    want.pixel_index, got.alpha, want.alpha));
        if (got.last_pixel !== want.last_pixel)
          report_mismatch($sformatf("pixel %0d last_pixel got %0b want %0b",
                                    want.pixel_index, got.last_pixel, want.last_pixel));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  dxtd_cfg_if cfg_if ();
  dxtd_blk_if blk_if ();
  dxtd_pix_if pix_if ();

  dxt_block_decoder i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .blk_i  (blk_if),
    .pix_o  (pix_if)
  );

  pixel_scoreboard sb;
  logic [1:0]      cur_format;
  bit              no_idle;
  int unsigned     hold_request;
  int unsigned     blocks_sent;
  int unsigned     blocks_per_format[4];

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Writes the format register; only called while the decoder is idle.
  task write_format(input logic [1:0] fmt);
    @(negedge clk);
    cfg_if.valid        <= 1'b1;
    cfg_if.block_format <= fmt;
    do @(posedge clk); while (!cfg_if.ready);
    cur_format = fmt;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Offers one block beat, with random gaps ahead of it unless no_idle is set; returns at the accepting edge.
  task send_block(input block_t blk);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      blk_if.valid <= 1'b0;
      @(negedge clk);
    end
    blk_if.valid      <= 1'b1;
    blk_if.alpha_word <= blk.alpha_word;
    blk_if.color0     <= blk.color0;
    blk_if.color1     <= blk.color1;
    blk_if.index_word <= blk.index_word;
    do @(posedge clk); while (!blk_if.ready);
    sb.note_block(cur_format, blk);
    blocks_sent++;
    blocks_per_format[cur_format]++;
  endtask

  // Lets every owed pixel come out, then lets the pipe settle.
  task drain_pixels();
    @(negedge clk);
    blk_if.valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  // Alpha word whose 3-bit ramp indices step 0..7 twice across the block.
  function automatic logic [63:0] ramp_word(input logic [7:0] a0, input logic [7:0] a1);
    logic [63:0] w;
    w        = '0;
    w[7:0]   = a0;
    w[15:8]  = a1;
    for (int i = 0; i < dxtd_pkg::NumPixels; i++) w[16+3*i +: 3] = i[2:0];
    return w;
  endfunction

  function automatic block_t random_block();
    block_t blk;
    blk.alpha_word = {$urandom, $urandom};
    blk.index_word = $urandom;
    blk.color0     = 16'($urandom);
    blk.color1     = 16'($urandom);
    // Bias toward equal endpoints and endpoint extremes now and then.
    case ($urandom_range(7))
      0: blk.color1 = blk.color0;
      1: blk.color0 = $urandom_range(1) ? 16'hffff : 16'h0000;
      2: blk.color1 = $urandom_range(1) ? 16'hffff : 16'h0000;
      default: ;
    endcase
    if ($urandom_range(7) == 0) blk.alpha_word[15:8] = blk.alpha_word[7:0];
    return blk;
  endfunction

  // Pixel receiver: random stalls unless no_idle is set, or a long hold-off counted here when requested.
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    pix_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (pix_if.valid && pix_if.ready)
        sb.check_pixel('{pix_if.pixel_index, pix_if.red, pix_if.green, pix_if.blue,
                         pix_if.alpha, pix_if.last_pixel});
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        pix_if.ready <= 1'b0;
        hold_left--;
      end else begin
        pix_if.ready <= no_idle || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Watchdog: ends the run when no beat of any kind moves for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if ((blk_if.valid && blk_if.ready) || (pix_if.valid && pix_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Timeout: no beat for %0d cycles, %0d pixels still owed",
             StallLimit, sb.pending_pixels.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence: directed blocks per format, then random phases.
  initial begin
    logic [1:0] phase_formats[7];
    sb                  = new();
    cur_format          = dxtd_pkg::FMT_DXT1;
    no_idle             = 1'b0;
    hold_request        = 0;
    blocks_sent         = 0;
    blocks_per_format   = '{0, 0, 0, 0};
    rst_n               = 1'b0;
    blk_if.valid        = 1'b0;
    blk_if.alpha_word   = '0;
    blk_if.color0       = '0;
    blk_if.color1       = '0;
    blk_if.index_word   = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.block_format = dxtd_pkg::FMT_DXT1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // DXT1 at its reset value: four-color, three-color with transparency, equal ends.
    send_block('{64'h0, 16'hffff, 16'h0000, 32'he4e4e4e4});
    send_block('{64'hffff_ffff_ffff_ffff, 16'h0000, 16'hffff, 32'h1b1b1b1b});
    send_block('{64'h0123_4567_89ab_cdef, 16'h8410, 16'h8410, 32'he4e4e4e4});
    send_block('{64'h0, 16'hf81f, 16'h07e0, 32'hffffffff});
    send_block('{64'h0, 16'h0000, 16'h0000, 32'h00000000});
    send_block('{64'h0, 16'h7bef, 16'h7bee, 32'h4e4e4e4e});
    drain_pixels();

    // DXT3: every nibble value, all zeros, all ones; always four-color.
    write_format(dxtd_pkg::FMT_DXT3);
    send_block('{64'hfedc_ba98_7654_3210, 16'hffff, 16'h0000, 32'he4e4e4e4});
    send_block('{64'h0, 16'h1234, 16'habcd, 32'h9c9c9c9c});
    send_block('{64'hffff_ffff_ffff_ffff, 16'h0000, 16'hffff, 32'he4e4e4e4});
    drain_pixels();

    // DXT5: eight-entry ramp, six-entry ramp with 0 and 255, equal endpoints.
    write_format(dxtd_pkg::FMT_DXT5);
    send_block('{ramp_word(8'hff, 8'h00), 16'hf800, 16'h001f, 32'he4e4e4e4});
    send_block('{ramp_word(8'h00, 8'hff), 16'h001f, 16'hf800, 32'h1b1b1b1b});
    send_block('{ramp_word(8'h80, 8'h80), 16'h07e0, 16'h07e0, 32'h4e4e4e4e});
    send_block('{ramp_word(8'h37, 8'hc9), 16'hffff, 16'hffff, 32'hffffffff});
    send_block('{64'h0, 16'h0000, 16'hffff, 32'h00000000});
    drain_pixels();

    // The spare format code behaves as DXT5.
    write_format(FMT_SPARE);
    send_block('{ramp_word(8'hc0, 8'h40), 16'h1234, 16'h4321, 32'he4e4e4e4});
    send_block('{ramp_word(8'h10, 8'hf0), 16'h0000, 16'h0000, 32'h1b1b1b1b});
    drain_pixels();

    // Random phases; the fifth runs without idling and with a long receiver hold-off.
    phase_formats = '{dxtd_pkg::FMT_DXT1, dxtd_pkg::FMT_DXT3, dxtd_pkg::FMT_DXT5, FMT_SPARE,
                      dxtd_pkg::FMT_DXT1, dxtd_pkg::FMT_DXT5, dxtd_pkg::FMT_DXT3};
    foreach (phase_formats[p]) begin
      write_format(phase_formats[p]);
      no_idle = (p == 4);
      if (p == 4) hold_request = HoldOffCyc;
      repeat (PhaseBlocks) send_block(random_block());
      drain_pixels();
      no_idle = 1'b0;
    end

    $display("Covered %0d blocks (DXT1 %0d, DXT3 %0d, DXT5 %0d, spare code %0d).",
             blocks_sent, blocks_per_format[dxtd_pkg::FMT_DXT1],
             blocks_per_format[dxtd_pkg::FMT_DXT3],
             blocks_per_format[dxtd_pkg::FMT_DXT5], blocks_per_format[FMT_SPARE]);
    $display("Checked %0d pixels, including a stalled output phase; %0d mismatches.",
             sb.pixels_checked, sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
